/* rtl/core/crf_pkg.sv */
`default_nettype none

package crf_pkg;

    localparam int RING_DEPTH = 64;
    localparam int ID_SPACE   = 2048;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int ID_W       = $clog2(ID_SPACE);
    localparam int MAX_LEN    = 8;

    localparam logic [1:0] CMD_RECV = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_MASK = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_EMPTY     = 3'd1;
    localparam logic [2:0] STAT_FILTERED  = 3'd2;
    localparam logic [2:0] STAT_OVERWRITE = 3'd3;
    localparam logic [2:0] STAT_BAD_ID    = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] frame_id;
        logic        mask_on;
        logic [3:0]  frame_len;
        logic        remote_req;
        logic [63:0] frame_bytes;
        logic [31:0] arrival_time;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] out_id;
        logic [3:0]  out_len;
        logic        out_rtr;
        logic [63:0] out_data;
        logic [31:0] out_time;
        logic [6:0]  unread_count;
    } rsp_item_t;

    typedef struct packed {
        logic        rtr;
        logic [3:0]  len;
        logic [10:0] id;
        logic [63:0] data;
        logic [31:0] stamp;
    } ring_entry_t;

endpackage

`default_nettype wire

/* rtl/core/crf_req_if.sv */
`default_nettype none

interface crf_req_if;
    logic               valid;
    logic               ready;
    crf_pkg::req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/core/crf_rsp_if.sv */
`default_nettype none

interface crf_rsp_if;
    logic               valid;
    logic               ready;
    crf_pkg::rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/core/can_rx_id_filter_ring.sv */
// an item is accepted in S_IDLE, its bitmap and ring reads are registered on accept, and
//   its result is registered when the item fires in S_EXEC, which a waiting result stalls
// no new item is accepted until the last has left S_EXEC, as ready is high only in S_IDLE;
//   the bitmap and ring memories are read on accept and written when the item fires
// reset: pointers and count clear at once, then a pass over all 2048 IDs clears the bitmap,
//   during which no item is accepted; ring contents are not cleared
`default_nettype none

module can_rx_id_filter_ring (
    input  wire logic clk,
    input  wire logic rst_n,
    crf_req_if.sink   req,
    crf_rsp_if.source rsp
);
    import crf_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic        bitmap_mem [ID_SPACE];
    ring_entry_t ring_mem   [RING_DEPTH];

    logic [1:0]       state_reg, state_next;
    logic [ID_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_item_t        rsp_item_reg, rsp_item_next;

    req_item_t   item_reg;
    logic        bm_rd_reg;
    ring_entry_t ring_rd_reg;

    logic        accept;
    logic        fire;
    logic        bm_we;
    logic [ID_W-1:0] bm_waddr;
    logic        bm_wdata;
    logic        ring_we;
    ring_entry_t ring_wdata;
    logic [3:0]  len_sat;
    logic        id_high;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign fire      = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.item  = rsp_item_reg;

    assign id_high = (item_reg.frame_id[15:ID_W] != '0);
    assign len_sat = (item_reg.frame_len > 4'(MAX_LEN)) ? 4'(MAX_LEN) : item_reg.frame_len;

    always_comb
    begin
        ring_wdata.rtr   = item_reg.remote_req;
        ring_wdata.len   = len_sat;
        ring_wdata.id    = item_reg.frame_id[ID_W-1:0];
        ring_wdata.stamp = item_reg.arrival_time;
        for (int i = 0; i < 8; i++)
        begin
            ring_wdata.data[i*8 +: 8] = (4'(i) < len_sat) ? item_reg.frame_bytes[i*8 +: 8]
                                                          : 8'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        read_ptr_next  = read_ptr_reg;
        write_ptr_next = write_ptr_reg;
        held_next      = held_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        bm_we          = 1'b0;
        bm_waddr       = item_reg.frame_id[ID_W-1:0];
        bm_wdata       = item_reg.mask_on;
        ring_we        = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                bm_we        = 1'b1;
                bm_waddr     = clr_cnt_reg;
                bm_wdata     = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ID_W'(ID_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    rsp_item_next = '0;
                    rsp_item_next.status = STAT_OK;
                    unique case (item_reg.cmd)
                        CMD_RECV:
                        begin
                            if (id_high || bm_rd_reg)
                            begin
                                rsp_item_next.status = STAT_FILTERED;
                            end
                            else
                            begin
                                ring_we = 1'b1;
                                write_ptr_next = (write_ptr_reg == PTR_W'(RING_DEPTH - 1))
                                                 ? '0 : write_ptr_reg + 1'b1;
                                if (held_reg >= CNT_W'(RING_DEPTH))
                                begin
                                    held_next = CNT_W'(RING_DEPTH);
                                    read_ptr_next = (read_ptr_reg == PTR_W'(RING_DEPTH - 1))
                                                    ? '0 : read_ptr_reg + 1'b1;
                                    rsp_item_next.status = STAT_OVERWRITE;
                                end
                                else
                                begin
                                    held_next = held_reg + 1'b1;
                                end
                            end
                        end
                        CMD_POP:
                        begin
                            if (held_reg == '0)
                            begin
                                rsp_item_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                rsp_item_next.out_id   = ring_rd_reg.id;
                                rsp_item_next.out_len  = ring_rd_reg.len;
                                rsp_item_next.out_rtr  = ring_rd_reg.rtr;
                                rsp_item_next.out_data = ring_rd_reg.data;
                                rsp_item_next.out_time = ring_rd_reg.stamp;
                                read_ptr_next = (read_ptr_reg == PTR_W'(RING_DEPTH - 1))
                                                ? '0 : read_ptr_reg + 1'b1;
                                held_next = held_reg - 1'b1;
                            end
                        end
                        CMD_MASK:
                        begin
                            if (id_high)
                            begin
                                rsp_item_next.status = STAT_BAD_ID;
                            end
                            else
                            begin
                                bm_we = 1'b1;
                            end
                        end
                        CMD_NOP:
                        begin
                            rsp_item_next.status = STAT_OK;
                        end
                    endcase
                    rsp_item_next.unread_count = 7'(held_next);
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            read_ptr_reg  <= '0;
            write_ptr_reg <= '0;
            held_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            read_ptr_reg  <= read_ptr_next;
            write_ptr_reg <= write_ptr_next;
            held_reg      <= held_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
        if (accept)
        begin
            item_reg <= req.item;
        end
    end

    // block bitmap
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bitmap_mem[bm_waddr] <= bm_wdata;
        end
        if (accept)
        begin
            bm_rd_reg <= bitmap_mem[req.item.frame_id[ID_W-1:0]];
        end
    end

    // frame ring
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[write_ptr_reg] <= ring_wdata;
        end
        if (accept)
        begin
            ring_rd_reg <= ring_mem[read_ptr_reg];
        end
    end

`ifndef NO_ASSERTIONS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(RING_DEPTH))
        else $error("held count above ring depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        write_ptr_reg == PTR_W'(read_ptr_reg + held_reg[PTR_W-1:0]))
        else $error("ring pointers disagree with held count");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("item accepted during bitmap clear");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result without an executed item");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC) && !req.ready)
        else $error("second item accepted while one is in flight");
`endif

endmodule

`default_nettype wire
